FILE: sv/csb_pkg.sv
package csb_pkg;

  localparam int NUM_SEMS_DEF     = 1024;
  localparam int MAX_WAITERS_DEF  = 256;
  localparam int TASK_ID_BITS_DEF = 16;

  localparam int FUNC_W   = 2;
  localparam int SEM_ID_W = 10;
  localparam int STATUS_W = 3;
  localparam int COUNT_W  = 9;

  localparam logic signed [COUNT_W-1:0] COUNT_MAX = {1'b0, {(COUNT_W-1){1'b1}}};
  localparam logic signed [COUNT_W-1:0] COUNT_MIN = {1'b1, {(COUNT_W-1){1'b0}}};

  typedef enum logic [FUNC_W-1:0] {
    FUNC_CREATE = 2'd0,
    FUNC_WAIT   = 2'd1,
    FUNC_SIGNAL = 2'd2
  } func_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 3'd0,
    ST_BLOCKED   = 3'd1,
    ST_FULL      = 3'd2,
    ST_BAD_ID    = 3'd3,
    ST_POOL_FULL = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SEM,
    S_WAKE
  } state_t;

  // Requests to the free-slot stack.
  typedef struct packed {
    logic rd;
    logic pop;
    logic push;
  } stack_ctl_t;

endpackage

FILE: sv/csb_free_stack.sv
module csb_free_stack #(
  parameter int DEPTH = csb_pkg::MAX_WAITERS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  csb_pkg::stack_ctl_t          ctl,
  input  logic [$clog2(DEPTH)-1:0]     push_data,
  output logic [$clog2(DEPTH+1)-1:0]   count,
  output logic [$clog2(DEPTH)-1:0]     rd_data
);

  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [IDX_W-1:0] stack_mem [DEPTH];

  logic [CNT_W-1:0] count_r, count_nxt;
  // Entries below the low-water mark were never written since reset; a read of
  // one of them returns its own index in place of the memory contents.
  logic [CNT_W-1:0] low_r, low_nxt;
  logic [CNT_W-1:0] top;
  logic [IDX_W-1:0] rd_idx_r;
  logic [IDX_W-1:0] rd_mem_r;
  logic             rd_init_r;

  assign top   = count_r - CNT_W'(1);
  assign count = count_r;
  assign rd_data = rd_init_r ? rd_idx_r : rd_mem_r;

  always_comb begin
    count_nxt = count_r;
    low_nxt   = low_r;
    if (ctl.pop) begin
      count_nxt = top;
      if (top < low_r) begin
        low_nxt = top;
      end
    end else if (ctl.push) begin
      count_nxt = count_r + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= CNT_W'(DEPTH);
      low_r   <= CNT_W'(DEPTH);
    end else begin
      count_r <= count_nxt;
      low_r   <= low_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.push) begin
      stack_mem[count_r[IDX_W-1:0]] <= push_data;
    end
    if (ctl.rd) begin
      rd_mem_r  <= stack_mem[top[IDX_W-1:0]];
      rd_idx_r  <= top[IDX_W-1:0];
      rd_init_r <= (top < low_r);
    end
  end

endmodule

FILE: sv/counting_semaphore_bank.sv
// Counting semaphore bank with per-semaphore FIFO wait queues in a shared waiter pool.
// The input beat is registered with a read of the semaphore memory; the result beat is
// registered from S_SEM, or from S_WAKE for a signal that wakes a task (one extra read of
// the waiter memory). A new item waits for the semaphore read-modify-write, and a stalled
// output holds the block. Reset clears control state only; the memories get no clearing
// pass, and the free-slot stack reads as slots in order through its low-water mark.
module counting_semaphore_bank #(
  parameter int NUM_SEMS     = csb_pkg::NUM_SEMS_DEF,
  parameter int MAX_WAITERS  = csb_pkg::MAX_WAITERS_DEF,
  parameter int TASK_ID_BITS = csb_pkg::TASK_ID_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [csb_pkg::FUNC_W-1:0]    in_func,
  input  logic [csb_pkg::SEM_ID_W-1:0]  in_sem_id,
  input  logic [TASK_ID_BITS-1:0]       in_task_id,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [csb_pkg::STATUS_W-1:0]  out_status,
  output logic [csb_pkg::SEM_ID_W-1:0]  out_new_id,
  output logic                          out_wake_valid,
  output logic [TASK_ID_BITS-1:0]       out_wake_task
);

  localparam int ID_W    = $clog2(NUM_SEMS);
  localparam int ALLOC_W = $clog2(NUM_SEMS + 1);
  localparam int SLOT_W  = $clog2(MAX_WAITERS);
  localparam int CNT_W   = $clog2(MAX_WAITERS + 1);
  localparam int COUNT_W = csb_pkg::COUNT_W;
  localparam int SEM_W   = COUNT_W + 2 * SLOT_W;

  // Semaphore entry: {count, queue head, queue tail}.
  logic [SEM_W-1:0]        sem_mem [NUM_SEMS];
  logic [TASK_ID_BITS-1:0] waiter_task_mem [MAX_WAITERS];
  logic [SLOT_W-1:0]       waiter_next_mem [MAX_WAITERS];

  csb_pkg::state_t state_r, state_nxt;

  logic [ALLOC_W-1:0]      alloc_r, alloc_nxt;
  logic [csb_pkg::FUNC_W-1:0] func_r;
  logic [ID_W-1:0]         id_r;
  logic [TASK_ID_BITS-1:0] task_r;
  logic                    bad_r;

  logic [SEM_W-1:0]        sem_rd_r;
  logic [TASK_ID_BITS-1:0] wtask_rd_r;
  logic [SLOT_W-1:0]       wnext_rd_r;

  logic                    out_valid_r;
  logic [csb_pkg::STATUS_W-1:0] out_status_r;
  logic [csb_pkg::SEM_ID_W-1:0] out_new_id_r;
  logic                    out_wake_valid_r;
  logic [TASK_ID_BITS-1:0] out_wake_task_r;

  logic                    accept;
  logic                    out_free;
  logic [31:0]             id_wide;
  logic [31:0]             alloc_wide;
  logic                    bad_in;

  logic signed [COUNT_W-1:0] cnt;
  logic [COUNT_W-1:0]      cnt_dec;
  logic [COUNT_W-1:0]      cnt_inc;
  logic [SLOT_W-1:0]       head;
  logic [SLOT_W-1:0]       tail;

  csb_pkg::stack_ctl_t     stk;
  logic [CNT_W-1:0]        stk_count;
  logic [SLOT_W-1:0]       stk_slot;

  logic                    finish;
  csb_pkg::status_t        res_status;
  logic [csb_pkg::SEM_ID_W-1:0] res_new_id;
  logic                    res_wake_valid;
  logic [TASK_ID_BITS-1:0] res_wake_task;

  logic                    sem_we;
  logic [ID_W-1:0]         sem_waddr;
  logic [SEM_W-1:0]        sem_wdata;
  logic                    wt_we;
  logic                    wn_we;
  logic                    wr_en;

  assign in_ready = (state_r == csb_pkg::S_IDLE);
  assign accept   = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;

  assign id_wide    = 32'(in_sem_id);
  assign alloc_wide = 32'(alloc_r);
  assign bad_in     = (id_wide >= alloc_wide) || (id_wide >= 32'(NUM_SEMS));

  assign cnt     = signed'(sem_rd_r[SEM_W-1 -: COUNT_W]);
  assign head    = sem_rd_r[2*SLOT_W-1 -: SLOT_W];
  assign tail    = sem_rd_r[SLOT_W-1:0];
  assign cnt_dec = cnt - COUNT_W'(1);
  assign cnt_inc = cnt + COUNT_W'(1);

  csb_free_stack #(
    .DEPTH (MAX_WAITERS)
  ) u_free_stack (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (stk),
    .push_data (head),
    .count     (stk_count),
    .rd_data   (stk_slot)
  );

  always_comb begin
    state_nxt      = state_r;
    alloc_nxt      = alloc_r;
    finish         = 1'b0;
    res_status     = csb_pkg::ST_OK;
    res_new_id     = '0;
    res_wake_valid = 1'b0;
    res_wake_task  = '0;
    sem_we         = 1'b0;
    sem_waddr      = id_r;
    sem_wdata      = sem_rd_r;
    wt_we          = 1'b0;
    wn_we          = 1'b0;
    wr_en          = 1'b0;
    stk            = '0;
    case (state_r)
      csb_pkg::S_IDLE: begin
        if (in_valid) begin
          stk.rd    = 1'b1;
          state_nxt = csb_pkg::S_SEM;
        end
      end
      csb_pkg::S_SEM: begin
        if (out_free) begin
          case (func_r)
            csb_pkg::FUNC_CREATE: begin
              finish = 1'b1;
              if (alloc_r >= ALLOC_W'(NUM_SEMS)) begin
                res_status = csb_pkg::ST_FULL;
              end else begin
                sem_we     = 1'b1;
                sem_waddr  = alloc_r[ID_W-1:0];
                sem_wdata  = {COUNT_W'(1), {(2*SLOT_W){1'b0}}};
                alloc_nxt  = alloc_r + ALLOC_W'(1);
                res_new_id = alloc_wide[csb_pkg::SEM_ID_W-1:0];
              end
            end
            csb_pkg::FUNC_WAIT: begin
              finish = 1'b1;
              if (bad_r) begin
                res_status = csb_pkg::ST_BAD_ID;
              end else if (cnt > 0) begin
                sem_we    = 1'b1;
                sem_wdata = {cnt_dec, head, tail};
              end else if (stk_count == '0 || cnt == csb_pkg::COUNT_MIN) begin
                res_status = csb_pkg::ST_POOL_FULL;
              end else begin
                // Append the caller; an empty queue takes the new slot as its head too.
                stk.pop    = 1'b1;
                wt_we      = 1'b1;
                wn_we      = (cnt < 0);
                sem_we     = 1'b1;
                sem_wdata  = {cnt_dec, (cnt < 0) ? head : stk_slot, stk_slot};
                res_status = csb_pkg::ST_BLOCKED;
              end
            end
            csb_pkg::FUNC_SIGNAL: begin
              if (bad_r) begin
                finish     = 1'b1;
                res_status = csb_pkg::ST_BAD_ID;
              end else if (cnt == csb_pkg::COUNT_MAX) begin
                finish = 1'b1;
              end else if (cnt >= 0) begin
                finish    = 1'b1;
                sem_we    = 1'b1;
                sem_wdata = {cnt_inc, head, tail};
              end else begin
                wr_en     = 1'b1;
                state_nxt = csb_pkg::S_WAKE;
              end
            end
            default: begin
              finish = 1'b1;
            end
          endcase
          if (finish) begin
            state_nxt = csb_pkg::S_IDLE;
          end
        end
      end
      csb_pkg::S_WAKE: begin
        if (out_free) begin
          finish         = 1'b1;
          res_wake_valid = 1'b1;
          res_wake_task  = wtask_rd_r;
          sem_we         = 1'b1;
          if (cnt_inc == '0) begin
            sem_wdata = {cnt_inc, {(2*SLOT_W){1'b0}}};
          end else begin
            sem_wdata = {cnt_inc, wnext_rd_r, tail};
          end
          stk.push  = (stk_count < CNT_W'(MAX_WAITERS));
          state_nxt = csb_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = csb_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= csb_pkg::S_IDLE;
      alloc_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      alloc_r <= alloc_nxt;
      if (finish) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      func_r <= in_func;
      id_r   <= id_wide[ID_W-1:0];
      task_r <= in_task_id;
      bad_r  <= bad_in;
    end
    if (finish) begin
      out_status_r     <= res_status;
      out_new_id_r     <= res_new_id;
      out_wake_valid_r <= res_wake_valid;
      out_wake_task_r  <= res_wake_task;
    end
  end

  always_ff @(posedge clk) begin
    if (sem_we) begin
      sem_mem[sem_waddr] <= sem_wdata;
    end
    if (accept) begin
      sem_rd_r <= sem_mem[id_wide[ID_W-1:0]];
    end
  end

  // The link of the last queued slot is never followed, so only the old tail is relinked.
  always_ff @(posedge clk) begin
    if (wt_we) begin
      waiter_task_mem[stk_slot] <= task_r;
    end
    if (wn_we) begin
      waiter_next_mem[tail] <= stk_slot;
    end
    if (wr_en) begin
      wtask_rd_r <= waiter_task_mem[head];
      wnext_rd_r <= waiter_next_mem[head];
    end
  end

  assign out_valid      = out_valid_r;
  assign out_status     = out_status_r;
  assign out_new_id     = out_new_id_r;
  assign out_wake_valid = out_wake_valid_r;
  assign out_wake_task  = out_wake_task_r;

endmodule

FILE: sim/counting_semaphore_bank_tb.sv
`timescale 1ns / 100ps

module counting_semaphore_bank_tb;

  localparam int NUM_SEMS      = csb_pkg::NUM_SEMS_DEF;
  localparam int POOL_SLOTS    = csb_pkg::MAX_WAITERS_DEF;
  localparam int TASK_W        = csb_pkg::TASK_ID_BITS_DEF;
  localparam int FN_W          = csb_pkg::FUNC_W;
  localparam int SID_W         = csb_pkg::SEM_ID_W;
  localparam int ST_W          = csb_pkg::STATUS_W;
  localparam int RANDOM_ITEMS  = 100;
  localparam int TAIL_ITEMS    = 20;
  localparam int TOP_SIGNALS   = 256;
  localparam int HOLD_CYCLES   = 300;
  localparam int DRAIN_CYCLES  = 20;
  localparam int CYCLE_LIMIT   = 200000;
  localparam int PRINT_LIMIT   = 40;
  localparam int N_DIRECTED    = 24;

  // The block has no operation on this code; it must answer with a plain ok.
  localparam logic [FN_W-1:0] FUNC_NONE = 2'd3;

  typedef struct packed {
    csb_pkg::status_t    status;
    logic [SID_W-1:0]    new_id;
    logic                wake;
    logic [TASK_W-1:0]   wake_task;
  } sem_result_t;

  typedef struct {
    logic [FN_W-1:0]     fn;
    logic [SID_W-1:0]    sid;
    logic [TASK_W-1:0]   tid;
    bit                  given;
    sem_result_t         res;
  } stim_row_t;

  localparam sem_result_t R_OK     = '{csb_pkg::ST_OK, 10'd0, 1'b0, 16'h0000};
  localparam sem_result_t R_NEW1   = '{csb_pkg::ST_OK, 10'd1, 1'b0, 16'h0000};
  localparam sem_result_t R_BAD_ID = '{csb_pkg::ST_BAD_ID, 10'd0, 1'b0, 16'h0000};

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic [FN_W-1:0]     in_func = '0;
  logic [SID_W-1:0]    in_sem_id = '0;
  logic [TASK_W-1:0]   in_task_id = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic [ST_W-1:0]     out_status;
  logic [SID_W-1:0]    out_new_id;
  logic                out_wake_valid;
  logic [TASK_W-1:0]   out_wake_task;

  int unsigned cycle_cnt = 0;
  int unsigned mismatches = 0;
  int unsigned items_sent = 0;
  bit          no_idle = 1'b0;
  bit          hold_req = 1'b0;

  sem_result_t pending_results[$];

  // Shadow of the semaphore bank.
  int                sem_cnt   [NUM_SEMS];
  int                sems_made = 0;
  logic [7:0]        q_head    [NUM_SEMS];
  logic [7:0]        q_tail    [NUM_SEMS];
  logic [TASK_W-1:0] slot_task [POOL_SLOTS];
  logic [7:0]        slot_link [POOL_SLOTS];
  logic [7:0]        free_stack[POOL_SLOTS];
  int                free_cnt  = POOL_SLOTS;

  stim_row_t directed_rows [N_DIRECTED] = '{
    '{csb_pkg::FUNC_WAIT,   10'd0,    16'h0000, 1'b1, R_BAD_ID},
    '{csb_pkg::FUNC_SIGNAL, 10'd1023, 16'hFFFF, 1'b1, R_BAD_ID},
    '{csb_pkg::FUNC_CREATE, 10'd0,    16'h0000, 1'b1, R_OK},
    '{csb_pkg::FUNC_CREATE, 10'd1023, 16'hFFFF, 1'b1, R_NEW1},
    '{FUNC_NONE,            10'd0,    16'h0000, 1'b1, R_OK},
    '{FUNC_NONE,            10'd1023, 16'hFFFF, 1'b1, R_OK},
    '{csb_pkg::FUNC_WAIT,   10'd0,    16'hFFFF, 1'b0, R_OK},
    '{csb_pkg::FUNC_WAIT,   10'd0,    16'h0000, 1'b0, R_OK},
    '{csb_pkg::FUNC_WAIT,   10'd0,    16'hA5A5, 1'b0, R_OK},
    '{csb_pkg::FUNC_WAIT,   10'd0,    16'hFFFF, 1'b0, R_OK},
    '{csb_pkg::FUNC_SIGNAL, 10'd0,    16'h1111, 1'b0, R_OK},
    '{csb_pkg::FUNC_SIGNAL, 10'd0,    16'h2222, 1'b0, R_OK},
    '{csb_pkg::FUNC_WAIT,   10'd0,    16'h5A5A, 1'b0, R_OK},
    '{csb_pkg::FUNC_SIGNAL, 10'd0,    16'h3333, 1'b0, R_OK},
    '{csb_pkg::FUNC_SIGNAL, 10'd0,    16'h4444, 1'b0, R_OK},
    '{csb_pkg::FUNC_SIGNAL, 10'd0,    16'h5555, 1'b0, R_OK},
    '{csb_pkg::FUNC_WAIT,   10'd2,    16'h6666, 1'b1, R_BAD_ID},
    '{csb_pkg::FUNC_CREATE, 10'd512,  16'h7777, 1'b0, R_OK},
    '{csb_pkg::FUNC_WAIT,   10'd2,    16'h1234, 1'b0, R_OK},
    '{csb_pkg::FUNC_WAIT,   10'd2,    16'h8001, 1'b0, R_OK},
    '{csb_pkg::FUNC_SIGNAL, 10'd1,    16'h0F0F, 1'b0, R_OK},
    '{csb_pkg::FUNC_SIGNAL, 10'd2,    16'hF0F0, 1'b0, R_OK},
    '{csb_pkg::FUNC_WAIT,   10'd1,    16'hC3C3, 1'b0, R_OK},
    '{csb_pkg::FUNC_SIGNAL, 10'd1,    16'h3C3C, 1'b0, R_OK}
  };

  counting_semaphore_bank u_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_func        (in_func),
    .in_sem_id      (in_sem_id),
    .in_task_id     (in_task_id),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_status     (out_status),
    .out_new_id     (out_new_id),
    .out_wake_valid (out_wake_valid),
    .out_wake_task  (out_wake_task)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("[counting_semaphore_bank] ERROR");
      $finish;
    end
  end

  function automatic logic [SID_W-1:0] rand_sid(input int lo, input int hi);
    return SID_W'($urandom_range(hi, lo));
  endfunction

  function automatic logic [TASK_W-1:0] rand_task();
    return TASK_W'($urandom());
  endfunction

  function automatic sem_result_t apply_sem_op(input logic [FN_W-1:0] fn,
                                               input logic [SID_W-1:0] sid,
                                               input logic [TASK_W-1:0] tid);
    sem_result_t r;
    int          c;
    logic [7:0]  slot;
    r = R_OK;
    case (fn)
      csb_pkg::FUNC_CREATE: begin
        if (sems_made >= NUM_SEMS) begin
          r.status = csb_pkg::ST_FULL;
        end else begin
          r.new_id = SID_W'(sems_made);
          sem_cnt[sems_made] = 1;
          sems_made++;
        end
      end
      csb_pkg::FUNC_WAIT, csb_pkg::FUNC_SIGNAL: begin
        if (int'(sid) >= sems_made) begin
          r.status = csb_pkg::ST_BAD_ID;
        end else if (fn == csb_pkg::FUNC_WAIT) begin
          c = sem_cnt[sid];
          if (c >= 1) begin
            sem_cnt[sid] = c - 1;
          end else if (free_cnt == 0 || c <= int'(csb_pkg::COUNT_MIN)) begin
            r.status = csb_pkg::ST_POOL_FULL;
          end else begin
            free_cnt--;
            slot = free_stack[free_cnt];
            slot_task[slot] = tid;
            slot_link[slot] = '0;
            // A negative count means the queue already has a tail to link from.
            if (c < 0) slot_link[q_tail[sid]] = slot;
            else q_head[sid] = slot;
            q_tail[sid] = slot;
            sem_cnt[sid] = c - 1;
            r.status = csb_pkg::ST_BLOCKED;
          end
        end else begin
          c = sem_cnt[sid];
          if (c < int'(csb_pkg::COUNT_MAX)) begin
            sem_cnt[sid] = c + 1;
            if (c < 0) begin
              slot = q_head[sid];
              r.wake = 1'b1;
              r.wake_task = slot_task[slot];
              q_head[sid] = slot_link[slot];
              free_stack[free_cnt] = slot;
              free_cnt++;
            end
          end
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic int idle_len();
    int r;
    r = int'($urandom_range(99, 0));
    if (no_idle || r < 55) return 0;
    if (r < 92) return int'($urandom_range(3, 1));
    return int'($urandom_range(40, 8));
  endfunction

  task automatic report_mismatch(input string what);
    mismatches++;
    if (mismatches <= PRINT_LIMIT) $display("mismatch at cycle %0d: %s", cycle_cnt, what);
  endtask

  task automatic send_item(input logic [FN_W-1:0] fn, input logic [SID_W-1:0] sid,
                           input logic [TASK_W-1:0] tid, input bit given = 1'b0,
                           input sem_result_t given_res = '0);
    int          gap;
    sem_result_t predicted;
    gap = idle_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_func    <= fn;
    in_sem_id  <= sid;
    in_task_id <= tid;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predicted = apply_sem_op(fn, sid, tid);
    pending_results.push_back(given ? given_res : predicted);
    items_sent++;
  endtask

  // Mostly operations on a few busy semaphores, some on any created one, some on ids
  // that were never handed out; with any_id set, operations on any id at all.
  task automatic random_op(input bit any_id);
    int                  r;
    int                  span;
    logic [FN_W-1:0]     fn;
    logic [SID_W-1:0]    sid;
    r = int'($urandom_range(99, 0));
    fn = (r < 8)  ? csb_pkg::FUNC_CREATE :
         (r < 50) ? csb_pkg::FUNC_WAIT :
         (r < 95) ? csb_pkg::FUNC_SIGNAL : FUNC_NONE;
    span = (sems_made < 6) ? sems_made : 6;
    r = int'($urandom_range(99, 0));
    if (any_id) sid = rand_sid(0, NUM_SEMS - 1);
    else if (r < 12 && sems_made < NUM_SEMS) sid = rand_sid(sems_made, NUM_SEMS - 1);
    else if (r < 27) sid = rand_sid(0, sems_made - 1);
    else sid = rand_sid(0, span - 1);
    send_item(fn, sid, rand_task());
  endtask

  always @(posedge clk) begin
    sem_result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result beat with nothing pending");
      end else begin
        want = pending_results.pop_front();
        if (out_status !== want.status)
          report_mismatch($sformatf("status %0d, want %0d", out_status, want.status));
        if (out_new_id !== want.new_id)
          report_mismatch($sformatf("new_id %0d, want %0d", out_new_id, want.new_id));
        if (out_wake_valid !== want.wake)
          report_mismatch($sformatf("wake_valid %0b, want %0b", out_wake_valid, want.wake));
        if (out_wake_task !== want.wake_task)
          report_mismatch($sformatf("wake_task %h, want %h", out_wake_task, want.wake_task));
      end
    end
  end

  // Receiver: random stalls, full rate while no_idle is set, and one long hold-off.
  initial begin
    int len;
    do @(posedge clk); while (!rst_n);
    forever begin
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end else if (no_idle) begin
        out_ready <= 1'b1;
        @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        repeat ($urandom_range(8, 1)) @(posedge clk);
        len = idle_len();
        if (len > 0) begin
          out_ready <= 1'b0;
          repeat (len) @(posedge clk);
        end
      end
    end
  end

  initial begin
    int               k;
    int               n;
    int               span;
    logic [SID_W-1:0] s;
    logic [SID_W-1:0] top_sem;
    for (int i = 0; i < POOL_SLOTS; i++) free_stack[i] = i[7:0];

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < N_DIRECTED; i++)
      send_item(directed_rows[i].fn, directed_rows[i].sid, directed_rows[i].tid,
                directed_rows[i].given, directed_rows[i].res);

    // The output side stalls for a long stretch right away, so the block backs up.
    hold_req = 1'b1;
    n = 0;
    while (n < RANDOM_ITEMS) begin
      no_idle = (n >= 40 && n < 70);
      if ($urandom_range(3, 0) == 0) begin
        // Send a run of waits on one semaphore, then as many signals; blocked tasks wake in order.
        span = (sems_made < 6) ? sems_made : 6;
        s = rand_sid(0, span - 1);
        k = int'($urandom_range(10, 1));
        repeat (k) send_item(csb_pkg::FUNC_WAIT, s, rand_task());
        repeat (k) send_item(csb_pkg::FUNC_SIGNAL, s, rand_task());
        n += 2 * k;
      end else begin
        random_op(1'b0);
        n++;
      end
    end
    no_idle = 1'b0;

    // Drive a fresh semaphore past the top of its count.
    top_sem = SID_W'(sems_made);
    send_item(csb_pkg::FUNC_CREATE, rand_sid(0, NUM_SEMS - 1), rand_task());
    repeat (TOP_SIGNALS) send_item(csb_pkg::FUNC_SIGNAL, top_sem, rand_task());

    repeat (TAIL_ITEMS) random_op(1'b1);

    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("[counting_semaphore_bank] OK");
    end else begin
      $display("[counting_semaphore_bank] ERROR");
    end
    $finish;
  end

endmodule

FILE: counting_semaphore_bank.f
sv/csb_pkg.sv
sv/csb_free_stack.sv
sv/counting_semaphore_bank.sv
sim/counting_semaphore_bank_tb.sv
